// ===== design/slpid_pkg.sv =====
// Shared types and constants for the slew-limited PID step block.
// Register index codes, coefficient bundle and fixed-point widths.
// No dependencies.
package slpid_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned ACC_W    = 67;
  localparam int unsigned FRAC_SH  = 20;
  localparam int unsigned IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_B0       = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1       = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2       = 3'd2;
  localparam logic [IDX_W-1:0] REG_A1       = 3'd3;
  localparam logic [IDX_W-1:0] REG_A2       = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_STEP = 3'd5;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (FRAC_SH - 1);
  localparam logic [STEP_W-1:0] MAX_STEP_RST = {STEP_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] b0;
    logic signed [DATA_W-1:0] b1;
    logic signed [DATA_W-1:0] b2;
    logic signed [DATA_W-1:0] a1;
    logic signed [DATA_W-1:0] a2;
    logic        [STEP_W-1:0] max_step;
  } pid_cfg_t;

endpackage

// ===== design/slpid_core.sv =====
// Recursive PID arithmetic: five products, rounding, saturation and slew clamp.
// Holds the error and output history, advanced on each step.
// Depends on slpid_pkg.
module slpid_core import slpid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic signed [DATA_W-1:0] err,
  input  pid_cfg_t                 cfg,
  output logic signed [DATA_W-1:0] drive,
  output logic signed [DATA_W-1:0] prev_drive
);

  logic signed [DATA_W-1:0] e1_r, e2_r, y1_r, y2_r;
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-FRAC_SH-1:0] shr;
  logic signed [DATA_W-1:0] raw;
  logic signed [DATA_W:0]   delta, lim_pos, lim_neg, delta_c;
  logic                     all_ones, all_zeros;

  assign p0 = PROD_W'(cfg.b0) * PROD_W'(err);
  assign p1 = PROD_W'(cfg.b1) * PROD_W'(e1_r);
  assign p2 = PROD_W'(cfg.b2) * PROD_W'(e2_r);
  assign p3 = PROD_W'(cfg.a1) * PROD_W'(y1_r);
  assign p4 = PROD_W'(cfg.a2) * PROD_W'(y2_r);

  assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4) + RND_BIAS;
  assign shr = acc[ACC_W-1:FRAC_SH];

  assign all_ones  = &shr[ACC_W-FRAC_SH-1:DATA_W-1];
  assign all_zeros = ~|shr[ACC_W-FRAC_SH-1:DATA_W-1];

  always_comb begin
    if (all_ones || all_zeros) begin
      raw = shr[DATA_W-1:0];
    end else if (shr[ACC_W-FRAC_SH-1]) begin
      raw = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      raw = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign delta   = (DATA_W+1)'(raw) - (DATA_W+1)'(y1_r);
  assign lim_pos = {2'b00, cfg.max_step};
  assign lim_neg = -lim_pos;

  always_comb begin
    if (delta > lim_pos) begin
      delta_c = lim_pos;
    end else if (delta < lim_neg) begin
      delta_c = lim_neg;
    end else begin
      delta_c = delta;
    end
  end

  assign drive      = DATA_W'((DATA_W+1)'(y1_r) + delta_c);
  assign prev_drive = y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r <= '0;
      e2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (step) begin
      e2_r <= e1_r;
      e1_r <= err;
      y2_r <= y1_r;
      y1_r <= drive;
    end
  end

endmodule

// ===== design/slew_limited_pid_step.sv =====
// Slew-limited PID step: one Q16.16 error request in, one Q16.16 drive value out.
// Accepts a request every cycle unless the output stalls; each result passes the
// input register, then the result register. The limit is the combinational
// multiply-accumulate, round, saturate and clamp in slpid_core, whose output feeds
// the next request. Write coefficients and max_step through cfg_* only while no
// request is in flight; the block does not enforce this. Depends on slpid_pkg, slpid_core.
module slew_limited_pid_step import slpid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] error_sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] drive_value
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  pid_cfg_t                 cfg_r;
  logic                     s1_valid_r, out_valid_r;
  logic signed [DATA_W-1:0] err_r;
  logic [DATA_W-1:0]        drive_r;
  logic                     out_ok, step;
  logic signed [DATA_W-1:0] drive, prev_drive;
  logic signed [DATA_W:0]   chk_delta;

  assign out_ok    = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_ok;
  assign in_tready = !s1_valid_r || out_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0       <= '0;
      cfg_r.b1       <= '0;
      cfg_r.b2       <= '0;
      cfg_r.a1       <= '0;
      cfg_r.a2       <= '0;
      cfg_r.max_step <= MAX_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:       cfg_r.b0       <= cfg_wdata;
        REG_B1:       cfg_r.b1       <= cfg_wdata;
        REG_B2:       cfg_r.b2       <= cfg_wdata;
        REG_A1:       cfg_r.a1       <= cfg_wdata;
        REG_A2:       cfg_r.a2       <= cfg_wdata;
        REG_MAX_STEP: cfg_r.max_step <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      err_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ok) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive_r <= drive;
    end
  end

  slpid_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .err        (err_r),
    .cfg        (cfg_r),
    .drive      (drive),
    .prev_drive (prev_drive)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;

  assign chk_delta = (DATA_W+1)'(drive) - (DATA_W+1)'(prev_drive);

  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("result register not loaded after step");

  a_slew_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (chk_delta <= $signed({2'b00, cfg_r.max_step})) &&
             (chk_delta >= -$signed({2'b00, cfg_r.max_step})))
    else $error("output change exceeds max_step");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule

// ===== tb/sv/tb_slew_limited_pid_step.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for slew_limited_pid_step: recursive PID sum, rounding,
// saturation and slew clamp predicted locally and compared per drive value.
// Depends on slpid_pkg and the slew_limited_pid_step RTL.
module tb_slew_limited_pid_step;
  import slpid_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef enum {ERR_FULL, ERR_SMALL, ERR_MIXED} err_mix_t;
  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STALLS} rx_mode_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata  = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  pid_cfg_t                 gains;
  logic signed [DATA_W-1:0] err_z1, err_z2, drive_z1, drive_z2;
  logic [DATA_W-1:0]        drive_expected[$];
  logic [DATA_W-1:0]        drive_want;
  int                       drive_mismatches = 0;
  int                       idle_cycles = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_hold = 0;
  int       rx_count = 0;

  slew_limited_pid_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [31:0] error_sample
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [31:0] drive_value
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_controller();
    gains    = '{b0: '0, b1: '0, b2: '0, a1: '0, a2: '0, max_step: MAX_STEP_RST};
    err_z1   = '0;
    err_z2   = '0;
    drive_z1 = '0;
    drive_z2 = '0;
  endfunction

  function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_B0:       gains.b0 = val;
      REG_B1:       gains.b1 = val;
      REG_B2:       gains.b2 = val;
      REG_A1:       gains.a1 = val;
      REG_A2:       gains.a2 = val;
      REG_MAX_STEP: gains.max_step = val[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] next_drive(input logic signed [DATA_W-1:0] err);
    logic signed [127:0] t_b0, t_b1, t_b2, t_a1, t_a2, acc;
    longint raw, delta, lim, y;
    t_b0 = longint'(gains.b0) * longint'(err);
    t_b1 = longint'(gains.b1) * longint'(err_z1);
    t_b2 = longint'(gains.b2) * longint'(err_z2);
    t_a1 = longint'(gains.a1) * longint'(drive_z1);
    t_a2 = longint'(gains.a2) * longint'(drive_z2);
    acc = t_b0 + t_b1 + t_b2 - t_a1 - t_a2 + (128'sd1 <<< (FRAC_SH - 1));
    acc = acc >>> FRAC_SH;
    if (acc > 128'sd2147483647) begin
      raw = 64'sd2147483647;
    end else if (acc < -128'sd2147483648) begin
      raw = -64'sd2147483648;
    end else begin
      raw = acc[63:0];
    end
    lim = gains.max_step;
    delta = raw - drive_z1;
    if (delta > lim) delta = lim;
    if (delta < -lim) delta = -lim;
    y = drive_z1 + delta;
    err_z2   = err_z1;
    err_z1   = err;
    drive_z2 = drive_z1;
    drive_z1 = y[DATA_W-1:0];
    return y[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] rand_error(input err_mix_t kind);
    logic [DATA_W-1:0] pick;
    case (kind)
      ERR_FULL:  pick = $urandom;
      ERR_SMALL: pick = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      default: begin
        case ($urandom_range(0, 5))
          0: pick = 32'h7FFF_FFFF;
          1: pick = 32'h8000_0000;
          2: pick = int'($urandom_range(0, 1 << 21)) - (1 << 20);
          3: pick = int'($urandom_range(0, 1 << 25)) - (1 << 24);
          default: pick = $urandom;
        endcase
      end
    endcase
    return pick;
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    logic [DATA_W-1:0] pick;
    case ($urandom_range(0, 5))
      0: pick = $urandom;
      1: pick = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      2: pick = int'($urandom_range(0, 1 << 17)) - (1 << 16);
      3: pick = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      4: pick = '0;
      default: begin
        case ($urandom_range(0, 3))
          0: pick = 32'h7FFF_FFFF;
          1: pick = 32'h8000_0000;
          2: pick = 32'h0010_0000;
          default: pick = 32'hFFF0_0000;
        endcase
      end
    endcase
    return pick;
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    logic [STEP_W-1:0] pick;
    case ($urandom_range(0, 7))
      0: pick = '0;
      1: pick = MAX_STEP_RST;
      2, 3: pick = STEP_W'($urandom);
      4: pick = STEP_W'($urandom_range(1, 16));
      default: pick = STEP_W'($urandom_range(0, 32'h0004_0000));
    endcase
    return pick;
  endfunction

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic cfg_idle();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input pid_cfg_t c);
    cfg_write(REG_B0, c.b0);
    cfg_write(REG_B1, c.b1);
    cfg_write(REG_B2, c.b2);
    cfg_write(REG_A1, c.a1);
    cfg_write(REG_A2, c.a2);
    cfg_write(REG_MAX_STEP, {1'b0, c.max_step});
    cfg_idle();
  endtask

  task automatic send_error(input logic [DATA_W-1:0] err);
    logic ready;
    in_tvalid <= 1'b1;
    in_tdata  <= err;
    do begin
      @(negedge clk);
      ready = in_tready;
      @(posedge clk);
    end while (!ready);
    drive_expected.push_back(next_drive(err));
  endtask

  task automatic wait_drained();
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  task automatic close_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
  endtask

  task automatic send_run(input int count, input err_mix_t kind);
    int burst, gap, sent;
    bit pause;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_error(rand_error(kind));
        sent++;
      end
      pause = ($urandom_range(0, 39) == 0);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (pause && gap == 0) gap = 1;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (pause) wait_drained();
      end
    end
    close_phase();
  endtask

  task automatic test_reset_defaults();
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    close_phase();
  endtask

  task automatic test_saturation();
    load_config('{b0: 32'h7FFF_FFFF, b1: 32'h8000_0000, b2: 32'h7FFF_FFFF,
                  a1: 32'h8000_0000, a2: 32'h7FFF_FFFF, max_step: MAX_STEP_RST});
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    send_error(32'h7FFF_FFFF);
    send_error(32'hFFFF_FFFF);
    send_error(32'h0000_0001);
    send_error(32'h0000_0000);
    close_phase();
  endtask

  task automatic test_rounding();
    load_config('{b0: 32'd1, b1: '0, b2: '0, a1: '0, a2: '0, max_step: MAX_STEP_RST});
    send_error(32'h0008_0000);
    send_error(32'h0007_FFFF);
    send_error(32'hFFF8_0000);
    send_error(32'hFFF7_FFFF);
    close_phase();
  endtask

  task automatic test_slew_clamp();
    load_config('{b0: 32'h0010_0000, b1: '0, b2: '0, a1: '0, a2: '0, max_step: 31'h100});
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    send_error(32'h0000_0050);
    close_phase();
  endtask

  task automatic test_zero_step();
    load_config('{b0: 32'h0010_0000, b1: 32'h0008_0000, b2: '0, a1: '0, a2: '0,
                  max_step: '0});
    send_error(32'h1234_5678);
    send_error(32'h8000_0000);
    close_phase();
  endtask

  task automatic test_register_edges();
    cfg_write(REG_MAX_STEP, 32'h8000_0010);
    for (int i = REG_MAX_STEP + 1; i < (1 << IDX_W); i++) cfg_write(IDX_W'(i), $urandom);
    cfg_idle();
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    close_phase();
    cfg_write(REG_MAX_STEP, 32'hFFFF_FFFF);
    cfg_idle();
    send_error(32'h7FFF_FFFF);
    close_phase();
  endtask

  task automatic test_random_traffic();
    pid_cfg_t c;
    err_mix_t kind;
    for (int phase = 0; phase < 12; phase++) begin
      c = '{b0: rand_gain(), b1: rand_gain(), b2: rand_gain(),
            a1: rand_gain(), a2: rand_gain(), max_step: rand_step()};
      load_config(c);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(IDX_W'(REG_MAX_STEP + 1 + $urandom_range(0, 1)), $urandom);
        cfg_idle();
      end
      case (phase % 3)
        0: kind = ERR_MIXED;
        1: kind = ERR_SMALL;
        default: kind = ERR_FULL;
      endcase
      send_run($urandom_range(130, 170), kind);
    end
  endtask

  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_tready <= (rx_count % 5) < 2;
      default: begin
        if (rx_hold != 0) begin
          out_tready <= 1'b0;
          rx_hold <= rx_hold - 1;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(4, 15);
        end
      end
    endcase
  end

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_expected.size() == 0) begin
        drive_mismatches++;
        if (drive_mismatches <= MAX_REPORTS)
          $display("drive_value %h with no request outstanding", out_tdata);
      end else begin
        drive_want = drive_expected.pop_front();
        if (out_tdata !== drive_want) begin
          drive_mismatches++;
          if (drive_mismatches <= MAX_REPORTS)
            $display("drive_value mismatch: expected %h, got %h", drive_want, out_tdata);
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** slew_limited_pid_step: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_controller();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_saturation();
    test_rounding();
    test_slew_clamp();
    test_zero_step();
    test_register_edges();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (drive_mismatches == 0) begin
      $display("** slew_limited_pid_step: PASSED **");
    end else begin
      $display("** slew_limited_pid_step: FAILED **");
    end
    $finish;
  end

endmodule
